@@ design/jsbs_pkg.sv @@
// Shared types and constants for the joint setpoint biquad smoother.
`default_nettype none

package jsbs_pkg;

  localparam int AXIS_COUNT = 6;
  localparam int AXIS_IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int LIMIT_ROWS = 6;
  localparam int ROW_W      = 3;

  localparam int COEFF_W = 48;
  localparam int CFG_IDX_W = 2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 2'd2;

  // item actions
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_INIT   = 1'b1;

  // joint limits in Q16.16 degrees
  localparam logic signed [31:0] LIM_LO [LIMIT_ROWS] = '{
    -32'sd11141120, -32'sd5570560, -32'sd11141120,
    -32'sd13762560, -32'sd8519680, -32'sd176947200
  };
  localparam logic signed [31:0] LIM_HI [LIMIT_ROWS] = '{
    32'sd11141120, 32'sd11468800, 32'sd0,
    32'sd13762560, 32'sd8519680, 32'sd176947200
  };

  typedef struct packed {
    logic signed [COEFF_W-1:0] b0;
    logic signed [COEFF_W-1:0] a1;
    logic signed [COEFF_W-1:0] a2;
  } coeff_t;

  typedef struct packed {
    logic              action;
    logic [2:0]        axis;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured_position;
    logic              drive_on;
  } item_t;

  typedef struct packed {
    logic              ready;
    logic signed [31:0] in1;
    logic signed [31:0] in2;
    logic signed [31:0] out1;
    logic signed [31:0] out2;
    logic signed [31:0] tgt;
    logic signed [31:0] vel;
  } axis_state_t;

  typedef struct packed {
    logic        wr_en;
    axis_state_t st;
  } state_upd_t;

  typedef struct packed {
    logic signed [31:0] target_position;
    logic signed [31:0] target_velocity;
    logic              clamped_low;
    logic              clamped_high;
  } result_t;

endpackage

`default_nettype wire

@@ design/jsbs_axis_state.sv @@
// Per-axis filter history, last target and ready flags.
`default_nettype none

module jsbs_axis_state
  import jsbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [AXIS_IDX_W-1:0] idx,
  output axis_state_t                rd,
  input  wire state_upd_t            upd
);

  logic signed [31:0] in1  [AXIS_COUNT];
  logic signed [31:0] in2  [AXIS_COUNT];
  logic signed [31:0] out1 [AXIS_COUNT];
  logic signed [31:0] out2 [AXIS_COUNT];
  logic signed [31:0] tgt  [AXIS_COUNT];
  logic signed [31:0] vel  [AXIS_COUNT];
  logic [AXIS_COUNT-1:0] ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= '0;
    end else if (upd.wr_en) begin
      ready[idx] <= upd.st.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.wr_en) begin
      in1[idx]  <= upd.st.in1;
      in2[idx]  <= upd.st.in2;
      out1[idx] <= upd.st.out1;
      out2[idx] <= upd.st.out2;
      tgt[idx]  <= upd.st.tgt;
      vel[idx]  <= upd.st.vel;
    end
  end

  always_comb begin
    rd.ready = ready[idx];
    rd.in1   = in1[idx];
    rd.in2   = in2[idx];
    rd.out1  = out1[idx];
    rd.out2  = out2[idx];
    rd.tgt   = tgt[idx];
    rd.vel   = vel[idx];
  end

endmodule

`default_nettype wire

@@ design/jsbs_filter.sv @@
// Biquad step, rounding, saturation, joint clamp and target update for one item.
`default_nettype none

module jsbs_filter
  import jsbs_pkg::*;
(
  input  wire coeff_t      coeff,
  input  wire item_t       item,
  input  wire logic        axis_ok,
  input  wire axis_state_t cur,
  output state_upd_t       upd,
  output result_t          res
);

  // exact c * v, coefficient split into signed high and unsigned low halves
  function automatic logic signed [83:0] coeff_mul(input logic signed [47:0] c,
                                                   input logic signed [33:0] v);
    logic signed [23:0] c_hi;
    logic signed [24:0] c_lo;
    logic signed [57:0] p_hi;
    logic signed [58:0] p_lo;
    c_hi = c[47:24];
    c_lo = $signed({1'b0, c[23:0]});
    p_hi = c_hi * v;
    p_lo = c_lo * v;
    return (84'(p_hi) <<< 24) + 84'(p_lo);
  endfunction

  logic signed [33:0] xs;
  logic signed [83:0] acc;
  logic signed [83:0] acc_rnd;
  logic signed [38:0] y_wide;
  logic signed [31:0] y;
  logic [ROW_W-1:0]   row;
  logic signed [31:0] lmin;
  logic signed [31:0] lmax;
  logic signed [31:0] c;
  logic               flo;
  logic               fhi;
  logic signed [32:0] diff;
  logic signed [31:0] dvel;
  logic               do_init;

  always_comb begin
    xs = 34'(item.setpoint) + (34'(cur.in1) <<< 1) + 34'(cur.in2);
    acc = coeff_mul(coeff.b0, xs)
        - coeff_mul(coeff.a1, 34'(cur.out1))
        - coeff_mul(coeff.a2, 34'(cur.out2));
    acc_rnd = acc + (84'sd1 <<< 44);
    y_wide = acc_rnd[83:45];
    if (y_wide[38:31] != {8{y_wide[38]}}) begin
      y = y_wide[38] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      y = y_wide[31:0];
    end

    row = (int'(item.axis) < LIMIT_ROWS) ? item.axis : ROW_W'(LIMIT_ROWS - 1);
    lmin = LIM_LO[row];
    lmax = LIM_HI[row];
    c = y;
    flo = 1'b0;
    fhi = 1'b0;
    if (y < lmin) begin
      c = lmin;
      flo = 1'b1;
    end
    if (y > lmax) begin
      c = lmax;
      fhi = 1'b1;
    end

    diff = 33'(c) - 33'(cur.tgt);
    if (diff[32] != diff[31]) begin
      dvel = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      dvel = diff[31:0];
    end

    do_init = (item.action == ACT_INIT) || !cur.ready;

    upd.wr_en    = axis_ok;
    upd.st.ready = 1'b1;
    if (do_init) begin
      upd.st.in1  = item.measured_position;
      upd.st.in2  = item.measured_position;
      upd.st.out1 = item.measured_position;
      upd.st.out2 = item.measured_position;
      upd.st.tgt  = item.measured_position;
      upd.st.vel  = '0;
    end else begin
      upd.st.in1  = item.setpoint;
      upd.st.in2  = cur.in1;
      upd.st.out1 = y;
      upd.st.out2 = cur.out1;
      upd.st.tgt  = item.drive_on ? c : cur.tgt;
      upd.st.vel  = item.drive_on ? dvel : cur.vel;
    end

    if (!axis_ok) begin
      res = '0;
    end else begin
      res.target_position = upd.st.tgt;
      res.target_velocity = upd.st.vel;
      res.clamped_low     = do_init ? 1'b0 : flo;
      res.clamped_high    = do_init ? 1'b0 : fhi;
    end
  end

endmodule

`default_nettype wire

@@ design/joint_setpoint_biquad_smoother.sv @@
// Top level of the per-axis joint setpoint biquad smoother.
//
// Input stream s_*: one item per transfer. tuser carries action (bit 0) and
// axis (bits 3:1); tdata carries setpoint, measured_position and drive_on.
// Output stream m_*: one result per input item, in input order.
// Config channel cfg_*: writes coefficient b0, a1 or a2 (index 0..2), always
// ready; write only while no item is in flight.
// Pipeline: an item goes from the input register to the result register. Throughput:
// one item per cycle while the output is not stalled. The filter step for an item reads
// and rewrites its axis history combinationally between the input and result
// registers, so items for the same axis may follow each other directly.
// Reset: all axes go not ready, coefficients clear to zero, both stages empty.
// The first sample of an axis after reset loads it from the measured angle.
// Stall: while m_tready is low the result is held; one more item is taken
// into the input register, after which s_tready drops until the result moves.
`default_nettype none

module joint_setpoint_biquad_smoother
  import jsbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [71:0]          s_tdata,  // setpoint, measured_position, drive_on, pad
  input  wire logic [3:0]           s_tuser,  // action, axis
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [71:0]               m_tdata,  // target_position, target_velocity,
                                              // clamped_low, clamped_high, pad
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEFF_W-1:0]   cfg_data
);

  coeff_t      coeff;
  logic        in_valid;
  item_t       in_item;
  logic        out_valid;
  result_t     out_res;
  logic        advance;
  logic        axis_ok;
  logic [AXIS_IDX_W-1:0] axis_idx;
  axis_state_t cur;
  state_upd_t  upd;
  state_upd_t  upd_gated;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_B0:  coeff.b0 <= $signed(cfg_data);
        REG_A1:  coeff.a1 <= $signed(cfg_data);
        REG_A2:  coeff.a2 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.action            <= s_tuser[0];
      in_item.axis              <= s_tuser[3:1];
      in_item.setpoint          <= $signed(s_tdata[31:0]);
      in_item.measured_position <= $signed(s_tdata[63:32]);
      in_item.drive_on          <= s_tdata[64];
    end
  end

  assign axis_ok  = int'(in_item.axis) < AXIS_COUNT;
  assign axis_idx = axis_ok ? AXIS_IDX_W'(in_item.axis) : '0;

  jsbs_axis_state u_state (
    .clk (clk),
    .rst (rst),
    .idx (axis_idx),
    .rd  (cur),
    .upd (upd_gated)
  );

  jsbs_filter u_filter (
    .coeff   (coeff),
    .item    (in_item),
    .axis_ok (axis_ok),
    .cur     (cur),
    .upd     (upd),
    .res     (res)
  );

  always_comb begin
    upd_gated       = upd;
    upd_gated.wr_en = upd.wr_en && advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.clamped_high, out_res.clamped_low,
                     out_res.target_velocity, out_res.target_position};

endmodule

`default_nettype wire

@@ design/jsbs_checker.sv @@
// Port-level checks for the joint setpoint biquad smoother.
`default_nettype none

module jsbs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[64] && m_tdata[65]))
    else $error("both clamp flags set");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind joint_setpoint_biquad_smoother jsbs_checker u_jsbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/smoother_checker.sv @@
// Checker for the joint setpoint smoother: predicts each result and compares it on transfer.
module smoother_checker
  import jsbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [71:0]          s_tdata,
  input  logic [3:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [71:0]          m_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEFF_W-1:0]   cfg_data,
  output int                   mismatches,
  output int                   pending
);

  localparam int JOINTS = 6;
  localparam int Q16 = 65536;
  localparam int LIMIT_DEG_LO [JOINTS] = '{-170, -85, -170, -210, -130, -2700};
  localparam int LIMIT_DEG_HI [JOINTS] = '{170, 175, 0, 210, 130, 2700};
  localparam logic signed [95:0] HALF_LSB = 96'sd1 <<< 44;
  localparam logic signed [95:0] MAX32 = 96'sd2147483647;
  localparam logic signed [95:0] MIN32 = -96'sd2147483648;

  logic signed [31:0] hist_x1 [JOINTS];
  logic signed [31:0] hist_x2 [JOINTS];
  logic signed [31:0] hist_y1 [JOINTS];
  logic signed [31:0] hist_y2 [JOINTS];
  logic signed [31:0] held_target [JOINTS];
  logic signed [31:0] held_velocity [JOINTS];
  logic               primed [JOINTS];
  logic signed [COEFF_W-1:0] gain_b0, gain_a1, gain_a2;
  result_t            expected_targets [$];
  int                 error_tally = 0;

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > MAX32) return 32'h7fffffff;
    if (v < MIN32) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic result_t smooth_axis(input logic action, input logic [2:0] axis,
                                          input logic signed [31:0] sp,
                                          input logic signed [31:0] meas, input logic drive);
    result_t r;
    logic signed [95:0] xs, acc, d;
    logic signed [31:0] y, c, lo_lim, hi_lim;
    int ax;
    r = '0;
    ax = int'(axis);
    if (ax < JOINTS) begin
      if (action == ACT_INIT || !primed[ax]) begin
        hist_x1[ax] = meas;
        hist_x2[ax] = meas;
        hist_y1[ax] = meas;
        hist_y2[ax] = meas;
        held_target[ax] = meas;
        held_velocity[ax] = '0;
        primed[ax] = 1'b1;
        r.target_position = meas;
      end else begin
        xs = sp + 2 * hist_x1[ax] + hist_x2[ax];
        acc = xs * gain_b0 - gain_a1 * hist_y1[ax] - gain_a2 * hist_y2[ax];
        y = sat32((acc + HALF_LSB) >>> 45);
        hist_x2[ax] = hist_x1[ax];
        hist_x1[ax] = sp;
        hist_y2[ax] = hist_y1[ax];
        hist_y1[ax] = y;
        lo_lim = LIMIT_DEG_LO[ax] * Q16;
        hi_lim = LIMIT_DEG_HI[ax] * Q16;
        c = y;
        if (y < lo_lim) begin
          c = lo_lim;
          r.clamped_low = 1'b1;
        end
        if (y > hi_lim) begin
          c = hi_lim;
          r.clamped_high = 1'b1;
        end
        if (drive) begin
          d = c - held_target[ax];
          held_velocity[ax] = sat32(d);
          held_target[ax] = c;
        end
        r.target_position = held_target[ax];
        r.target_velocity = held_velocity[ax];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      for (int i = 0; i < JOINTS; i++) begin
        hist_x1[i] = '0;
        hist_x2[i] = '0;
        hist_y1[i] = '0;
        hist_y2[i] = '0;
        held_target[i] = '0;
        held_velocity[i] = '0;
        primed[i] = 1'b0;
      end
      gain_b0 = '0;
      gain_a1 = '0;
      gain_a2 = '0;
      expected_targets.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_B0: gain_b0 = cfg_data;
          REG_A1: gain_a1 = cfg_data;
          REG_A2: gain_a2 = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.target_position = m_tdata[31:0];
        got.target_velocity = m_tdata[63:32];
        got.clamped_low = m_tdata[64];
        got.clamped_high = m_tdata[65];
        if (expected_targets.size() == 0) begin
          $error("result transfer with no item outstanding");
          error_tally++;
        end else begin
          want = expected_targets.pop_front();
          if (got.target_position !== want.target_position) begin
            $error("target_position: expected %0d, got %0d",
                   want.target_position, got.target_position);
            error_tally++;
          end
          if (got.target_velocity !== want.target_velocity) begin
            $error("target_velocity: expected %0d, got %0d",
                   want.target_velocity, got.target_velocity);
            error_tally++;
          end
          if (got.clamped_low !== want.clamped_low) begin
            $error("clamped_low: expected %0d, got %0d", want.clamped_low, got.clamped_low);
            error_tally++;
          end
          if (got.clamped_high !== want.clamped_high) begin
            $error("clamped_high: expected %0d, got %0d", want.clamped_high, got.clamped_high);
            error_tally++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_targets.push_back(smooth_axis(s_tuser[0], s_tuser[3:1], s_tdata[31:0],
                                               s_tdata[63:32], s_tdata[64]));
    end
    mismatches <= error_tally;
    pending <= expected_targets.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the joint setpoint smoother: clock, reset, stimulus and verdict.
module tb;
  import jsbs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [31:0] ANG_MAX = 32'h7fffffff;
  localparam logic [31:0] ANG_MIN = 32'h80000000;
  localparam logic [31:0] DEG = 32'd65536;
  localparam logic [COEFF_W-1:0] GAIN_MAX = 48'h7fffffffffff;
  localparam logic [COEFF_W-1:0] GAIN_MIN = 48'h800000000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [71:0]          s_tdata = '0;  // setpoint, measured_position, drive_on, pad
  logic [3:0]           s_tuser = '0;  // action, axis
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [71:0]          m_tdata;       // target_position, target_velocity,
                                       // clamped_low, clamped_high, pad
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0]   cfg_data = '0;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  always #6 clk = ~clk;

  joint_setpoint_biquad_smoother DUT (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  smoother_checker u_check (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pending
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("joint_setpoint_biquad_smoother test failed");
      $finish;
    end
  end

  // result side: random stall modes, plus one long hold-off on request
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(4, 60);
        end
        left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 5) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

  task automatic offer(input logic action, input logic [2:0] axis, input logic [31:0] sp,
                       input logic [31:0] meas, input logic drive);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= {axis, action};
    s_tdata <= {7'b0, drive, meas, sp};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_gains(input logic [COEFF_W-1:0] b0, input logic [COEFF_W-1:0] a1,
                             input logic [COEFF_W-1:0] a2);
    settle();
    write_reg(REG_B0, b0);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 11))
      0: return $urandom();
      1: return ANG_MIN;
      2: return ANG_MAX;
      3: return '0;
      default: return int'($urandom_range(0, 400000000)) - 200000000;
    endcase
  endfunction

  task automatic run_random(input int count, input int hold_at);
    logic [2:0] axis;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at)
        hold_req = 1'b1;
      axis = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
      offer(($urandom_range(0, 24) == 0) ? ACT_INIT : ACT_SAMPLE, axis, pick_angle(),
            pick_angle(), $urandom_range(0, 6) != 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // gains still at reset: first sample primes, second filters to zero
    offer(ACT_SAMPLE, 3'd0, 32'd5 * DEG, 32'd12 * DEG, 1'b1);
    offer(ACT_SAMPLE, 3'd0, 32'd5 * DEG, 32'd12 * DEG, 1'b1);
    offer(ACT_SAMPLE, 3'd6, ANG_MAX, ANG_MAX, 1'b1);
    offer(ACT_INIT, 3'd7, ANG_MIN, ANG_MIN, 1'b1);

    // averaging filter, unity DC gain
    write_gains(48'h0800_0000_0000, '0, '0);
    offer(ACT_INIT, 3'd1, '0, 32'd100 * DEG, 1'b0);
    offer(ACT_SAMPLE, 3'd1, ANG_MAX, '0, 1'b1);
    offer(ACT_SAMPLE, 3'd1, ANG_MIN, '0, 1'b1);
    offer(ACT_SAMPLE, 3'd1, ANG_MIN, '0, 1'b1);
    // velocity saturates high: target starts at the most negative angle
    offer(ACT_INIT, 3'd5, '0, ANG_MIN, 1'b1);
    offer(ACT_SAMPLE, 3'd5, ANG_MAX, '0, 1'b0);
    offer(ACT_SAMPLE, 3'd5, ANG_MAX, '0, 1'b0);
    offer(ACT_SAMPLE, 3'd5, ANG_MAX, '0, 1'b1);
    // velocity saturates low
    offer(ACT_INIT, 3'd4, '0, ANG_MAX, 1'b1);
    offer(ACT_SAMPLE, 3'd4, ANG_MIN, '0, 1'b0);
    offer(ACT_SAMPLE, 3'd4, ANG_MIN, '0, 1'b0);
    offer(ACT_SAMPLE, 3'd4, ANG_MIN, '0, 1'b1);
    // axis with zero upper limit
    offer(ACT_SAMPLE, 3'd2, '0, 32'd5 * DEG, 1'b1);
    offer(ACT_SAMPLE, 3'd2, '0, '0, 1'b1);
    offer(ACT_SAMPLE, 3'd2, 32'd50 * DEG, '0, 1'b1);
    offer(ACT_INIT, 3'd3, '0, 32'hffffffff, 1'b1);
    offer(ACT_SAMPLE, 3'd3, 32'hffffffff, '0, 1'b1);
    offer(ACT_SAMPLE, 3'd6, ANG_MAX, ANG_MIN, 1'b0);
    offer(ACT_SAMPLE, 3'd7, ANG_MIN, ANG_MAX, 1'b1);

    // damped low-pass: b0 0.0625, a1 -1.125, a2 0.375
    write_gains(48'h0200_0000_0000, 48'hdc00_0000_0000, 48'h0c00_0000_0000);
    run_random(500, 250);
    write_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX);
    run_random(150, -1);
    write_gains(GAIN_MIN, GAIN_MAX, GAIN_MIN);
    run_random(150, -1);
    write_gains(48'h0800_0000_0000, '0, '0);
    run_random(300, -1);
    write_gains(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                48'({$urandom(), $urandom()}));
    run_random(150, -1);
    write_gains(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                48'({$urandom(), $urandom()}));
    run_random(150, -1);

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("joint_setpoint_biquad_smoother test passed");
    else
      $display("joint_setpoint_biquad_smoother test failed");
    $finish;
  end

endmodule
